// ----- rtl/core/hetb_pkg.sv -----
`default_nettype none

package hetb_pkg;

    // Table sizes
    localparam int MAX_HALF_EDGES = 16384;
    localparam int MAX_EDGES      = 8192;
    localparam int MAX_FACES      = 8192;
    localparam int MAX_VALENCE    = 16;

    // Field widths
    localparam int VERTEX_BITS = 16;
    localparam int POS_W       = 4;
    localparam int VAL_W       = 5;
    localparam int HE_W        = 14;
    localparam int FACE_W      = 13;
    localparam int EDGE_W      = 13;
    localparam int HE_CNT_W    = 15;
    localparam int FACE_CNT_W  = 14;
    localparam int EDGE_CNT_W  = 14;
    localparam int KEY_W       = 2 * VERTEX_BITS;
    localparam int ENTRY_W     = KEY_W + HE_W;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    typedef logic [VERTEX_BITS-1:0] t_vertex;
    typedef logic [POS_W-1:0]       t_pos;
    typedef logic [VAL_W-1:0]       t_val;
    typedef logic [HE_W-1:0]        t_he;
    typedef logic [FACE_W-1:0]      t_face;
    typedef logic [EDGE_W-1:0]      t_edge;
    typedef logic [HE_CNT_W-1:0]    t_he_cnt;
    typedef logic [FACE_CNT_W-1:0]  t_face_cnt;
    typedef logic [EDGE_CNT_W-1:0]  t_edge_cnt;
    typedef logic [KEY_W-1:0]       t_key;

    // One classified corner, as handed from front to back
    typedef struct packed {
        t_key  key;
        logic  first;
        logic  last;
        t_val  val;
    } t_work;

    // Result word
    typedef struct packed {
        t_he   half_edge;
        t_he   prev_half_edge;
        t_he   next_half_edge;
        t_face face_number;
        t_edge edge_number;
        logic  edge_is_new;
        logic  has_twin;
        t_he   twin_half_edge;
        logic  overflow;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/hetb_ram.sv -----
`default_nettype none

module hetb_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  wire logic [P_WIDTH-1:0]         i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic      [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/hetb_front.sv -----
`default_nettype none

module hetb_front (
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire hetb_pkg::t_vertex i_origin_vertex,
    input  wire hetb_pkg::t_vertex i_dest_vertex,
    input  wire hetb_pkg::t_pos    i_corner_position,
    input  wire hetb_pkg::t_val    i_face_valence,
    output logic                   o_push_valid,
    input  wire logic              i_push_ready,
    output hetb_pkg::t_work        o_push_work
);

    hetb_pkg::t_vertex lo_v;
    hetb_pkg::t_vertex hi_v;
    hetb_pkg::t_val    val;

    // Order the vertex pair so both directions give one key
    always_comb begin
        if (i_origin_vertex < i_dest_vertex) begin
            lo_v = i_origin_vertex;
            hi_v = i_dest_vertex;
        end else begin
            lo_v = i_dest_vertex;
            hi_v = i_origin_vertex;
        end
    end

    // Clamp the valence: zero counts as one, saturate at the maximum
    always_comb begin
        priority if (i_face_valence == '0) begin
            val = hetb_pkg::t_val'(1);
        end else if (i_face_valence > hetb_pkg::t_val'(hetb_pkg::MAX_VALENCE)) begin
            val = hetb_pkg::t_val'(hetb_pkg::MAX_VALENCE);
        end else begin
            val = i_face_valence;
        end
    end

    // Classify the corner and push it
    always_comb begin
        o_push_work.key   = {lo_v, hi_v};
        o_push_work.first = (i_corner_position == '0);
        o_push_work.last  = (hetb_pkg::t_val'(i_corner_position) == val - hetb_pkg::t_val'(1));
        o_push_work.val   = val;
    end

    assign o_push_valid = i_valid;
    assign o_ready      = i_push_ready;

endmodule

`default_nettype wire

// ----- rtl/core/hetb_queue.sv -----
`default_nettype none

module hetb_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push_valid,
    output logic                 o_push_ready,
    input  wire hetb_pkg::t_work i_push_work,
    output logic                 o_pop_valid,
    input  wire logic            i_pop_ready,
    output hetb_pkg::t_work      o_pop_work
);

    hetb_pkg::t_work               r_slot [hetb_pkg::QUEUE_DEPTH];
    logic [hetb_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [hetb_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [hetb_pkg::QUEUE_CW-1:0] r_count;
    logic                          push;
    logic                          pop;

    assign o_push_ready = (r_count != hetb_pkg::QUEUE_CW'(hetb_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_work   = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + hetb_pkg::QUEUE_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + hetb_pkg::QUEUE_AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + hetb_pkg::QUEUE_CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - hetb_pkg::QUEUE_CW'(1);
            end
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_work;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/hetb_back.sv -----
`default_nettype none

module hetb_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_pop_valid,
    output logic                 o_pop_ready,
    input  wire hetb_pkg::t_work i_pop_work,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output hetb_pkg::t_result    o_result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]                   r_state, n_state;
    hetb_pkg::t_work              r_work;
    hetb_pkg::t_edge_cnt          r_addr, n_addr;
    logic                         r_cmp_vld, n_cmp_vld;
    hetb_pkg::t_edge              r_cmp_idx, n_cmp_idx;
    logic                         r_hit, n_hit;
    hetb_pkg::t_edge              r_found, n_found;
    hetb_pkg::t_he                r_twin, n_twin;
    hetb_pkg::t_he_cnt            r_he_cnt, n_he_cnt;
    hetb_pkg::t_face_cnt          r_face_cnt, n_face_cnt;
    hetb_pkg::t_edge_cnt          r_edge_cnt, n_edge_cnt;
    logic                         r_out_vld, n_out_vld;
    hetb_pkg::t_result            r_out, n_out;

    logic                         ram_we;
    logic                         ram_re;
    logic [hetb_pkg::ENTRY_W-1:0] ram_wdata;
    logic [hetb_pkg::ENTRY_W-1:0] ram_rdata;
    hetb_pkg::t_key               rd_key;
    hetb_pkg::t_he                rd_he;
    logic                         match;
    logic                         out_free;
    logic                         ovf;
    hetb_pkg::t_he                h;
    hetb_pkg::t_face              face;

    // Edge table: key and first half-edge side by side
    hetb_ram #(
        .P_WIDTH (hetb_pkg::ENTRY_W),
        .P_DEPTH (hetb_pkg::MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_edge_cnt[hetb_pkg::EDGE_W-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr[hetb_pkg::EDGE_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_key      = ram_rdata[hetb_pkg::ENTRY_W-1:hetb_pkg::HE_W];
    assign rd_he       = ram_rdata[hetb_pkg::HE_W-1:0];
    assign match       = r_cmp_vld && (rd_key == r_work.key);
    assign out_free    = !r_out_vld || i_ready;
    assign o_pop_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_vld;
    assign o_result    = r_out;
    assign h           = r_he_cnt[hetb_pkg::HE_W-1:0];
    assign ram_wdata   = {r_work.key, h};

    // Table-full check
    assign ovf = (r_he_cnt >= hetb_pkg::t_he_cnt'(hetb_pkg::MAX_HALF_EDGES))
              || (r_work.first && r_face_cnt >= hetb_pkg::t_face_cnt'(hetb_pkg::MAX_FACES))
              || (!r_hit && r_edge_cnt >= hetb_pkg::t_edge_cnt'(hetb_pkg::MAX_EDGES));

    // Face of this corner; a corner before any face start lands in face zero
    always_comb begin
        if (r_work.first) begin
            face = r_face_cnt[hetb_pkg::FACE_W-1:0];
        end else if (r_face_cnt == '0) begin
            face = '0;
        end else begin
            face = hetb_pkg::t_face'(r_face_cnt - hetb_pkg::t_face_cnt'(1));
        end
    end

    // Scan the edge table one entry a cycle, then finish the corner
    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_idx  = r_cmp_idx;
        n_hit      = r_hit;
        n_found    = r_found;
        n_twin     = r_twin;
        n_he_cnt   = r_he_cnt;
        n_face_cnt = r_face_cnt;
        n_edge_cnt = r_edge_cnt;
        n_out_vld  = r_out_vld && !i_ready;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_pop_valid) begin
                    n_addr    = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                priority if (match) begin
                    n_hit     = 1'b1;
                    n_found   = r_cmp_idx;
                    n_twin    = rd_he;
                    n_cmp_vld = 1'b0;
                    n_state   = S_FIN;
                end else if (r_addr < r_edge_cnt) begin
                    ram_re    = 1'b1;
                    n_addr    = r_addr + hetb_pkg::t_edge_cnt'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_addr[hetb_pkg::EDGE_W-1:0];
                end else if (!r_cmp_vld) begin
                    n_hit   = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_cmp_vld = 1'b0;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                    n_out     = '0;
                    if (ovf) begin
                        n_out.overflow = 1'b1;
                    end else begin
                        n_out.half_edge      = h;
                        n_out.prev_half_edge = h - hetb_pkg::t_he'(1)
                            + (r_work.first ? hetb_pkg::t_he'(r_work.val) : '0);
                        n_out.next_half_edge = h + hetb_pkg::t_he'(1)
                            - (r_work.last ? hetb_pkg::t_he'(r_work.val) : '0);
                        n_out.face_number    = face;
                        n_he_cnt             = r_he_cnt + hetb_pkg::t_he_cnt'(1);
                        if (r_work.first) begin
                            n_face_cnt = r_face_cnt + hetb_pkg::t_face_cnt'(1);
                        end
                        if (r_hit) begin
                            n_out.edge_number    = r_found;
                            n_out.has_twin       = 1'b1;
                            n_out.twin_half_edge = r_twin;
                        end else begin
                            ram_we             = 1'b1;
                            n_out.edge_number  = r_edge_cnt[hetb_pkg::EDGE_W-1:0];
                            n_out.edge_is_new  = 1'b1;
                            n_edge_cnt         = r_edge_cnt + hetb_pkg::t_edge_cnt'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cmp_vld  <= 1'b0;
            r_he_cnt   <= '0;
            r_face_cnt <= '0;
            r_edge_cnt <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmp_vld  <= n_cmp_vld;
            r_he_cnt   <= n_he_cnt;
            r_face_cnt <= n_face_cnt;
            r_edge_cnt <= n_edge_cnt;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_pop_ready && i_pop_valid) begin
            r_work <= i_pop_work;
        end
        r_addr    <= n_addr;
        r_cmp_idx <= n_cmp_idx;
        r_hit     <= n_hit;
        r_found   <= n_found;
        r_twin    <= n_twin;
        r_out     <= n_out;
    end

endmodule

`default_nettype wire

// ----- rtl/core/half_edge_twin_builder.sv -----
`default_nettype none

// Half-edge connectivity builder: feed one face corner per word (vertex, next
// vertex, position in face, face valence) and get one result word back per
// corner, in order, with the half-edge number, its prev/next inside the face,
// the face number, the undirected edge number and the twin (first half-edge
// of an edge already seen). A two-word queue decouples input acceptance from
// the edge lookup, so input words keep flowing while a result waits, until
// the queue is full. The lookup reads the stored edges in order up to the
// matching entry (all of them for a new edge) through the edge memory's
// single read port, one entry per cycle. The edge memory needs no clearing
// after reset; only entries below the edge count are ever read. When a
// table is full the result carries only the overflow flag and nothing is
// stored.
module half_edge_twin_builder (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire hetb_pkg::t_vertex i_origin_vertex,
    input  wire hetb_pkg::t_vertex i_dest_vertex,
    input  wire hetb_pkg::t_pos    i_corner_position,
    input  wire hetb_pkg::t_val    i_face_valence,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output hetb_pkg::t_he          o_half_edge,
    output hetb_pkg::t_he          o_prev_half_edge,
    output hetb_pkg::t_he          o_next_half_edge,
    output hetb_pkg::t_face        o_face_number,
    output hetb_pkg::t_edge        o_edge_number,
    output logic                   o_edge_is_new,
    output logic                   o_has_twin,
    output hetb_pkg::t_he          o_twin_half_edge,
    output logic                   o_overflow
);

    logic              push_valid;
    logic              push_ready;
    hetb_pkg::t_work   push_work;
    logic              pop_valid;
    logic              pop_ready;
    hetb_pkg::t_work   pop_work;
    hetb_pkg::t_result result;

    // Accept and classify corners
    hetb_front u_front (
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_origin_vertex   (i_origin_vertex),
        .i_dest_vertex     (i_dest_vertex),
        .i_corner_position (i_corner_position),
        .i_face_valence    (i_face_valence),
        .o_push_valid      (push_valid),
        .i_push_ready      (push_ready),
        .o_push_work       (push_work)
    );

    // Hold classified corners between front and back
    hetb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_work  (push_work),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_work   (pop_work)
    );

    // Look up edges, number everything, drive results
    hetb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_work  (pop_work),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (result)
    );

    assign o_half_edge      = result.half_edge;
    assign o_prev_half_edge = result.prev_half_edge;
    assign o_next_half_edge = result.next_half_edge;
    assign o_face_number    = result.face_number;
    assign o_edge_number    = result.edge_number;
    assign o_edge_is_new    = result.edge_is_new;
    assign o_has_twin       = result.has_twin;
    assign o_twin_half_edge = result.twin_half_edge;
    assign o_overflow       = result.overflow;

endmodule

`default_nettype wire

// ----- tb/sv/half_edge_twin_builder_tb.sv -----
`default_nettype none

module half_edge_twin_builder_tb;
    import hetb_pkg::*;

    // Cycles with no word moving on either side before the run is declared hung
    localparam int STALL_LIMIT   = 5000;
    // Receiver hold-off used to fill the block and stall its input
    localparam int LONG_HOLD     = 300;
    // Quiet cycles after the last result, above the longest lookup
    localparam int SETTLE_CYCLES = 400;
    // Small vertex set keeps the edge table, and so the lookup time, bounded
    localparam int POOL_SIZE     = 20;
    localparam int MAX_REPORTS   = 100;

    typedef enum int {
        PACE_OPEN,
        PACE_COIN,
        PACE_MOSTLY,
        PACE_PULSE
    } t_pace;

    logic     i_clk             = 1'b0;
    logic     i_rst_n           = 1'b0;
    logic     i_valid           = 1'b0;
    logic     o_ready;
    t_vertex  i_origin_vertex   = '0;
    t_vertex  i_dest_vertex     = '0;
    t_pos     i_corner_position = '0;
    t_val     i_face_valence    = '0;
    logic     o_valid;
    logic     i_ready           = 1'b0;
    t_he      o_half_edge;
    t_he      o_prev_half_edge;
    t_he      o_next_half_edge;
    t_face    o_face_number;
    t_edge    o_edge_number;
    logic     o_edge_is_new;
    logic     o_has_twin;
    t_he      o_twin_half_edge;
    logic     o_overflow;

    // Mesh state as the block should hold it
    int unsigned he_count;
    int unsigned face_count;
    int unsigned edge_total;
    int unsigned edge_index_of [bit [KEY_W-1:0]];
    t_he         edge_first_he [$];
    t_result     expected_words [$];

    t_vertex     pool_vertex [POOL_SIZE];
    int unsigned burst_left;
    int unsigned items_sent;
    int unsigned faces_sent;
    int unsigned twins_seen;
    int unsigned overflows_seen;
    int unsigned words_checked;
    int unsigned failures;
    int unsigned reports;
    int unsigned quiet_cycles;
    bit          hold_request;
    int unsigned hold_left;
    int unsigned pace_left;
    t_pace       pace_kind;

    half_edge_twin_builder dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Work out the result word for one corner and advance the mesh state
    function automatic t_result predict_corner(t_vertex org, t_vertex dst, t_pos pos, t_val val);
        t_result          r;
        bit [KEY_W-1:0]   key;
        int unsigned      v;
        int               prev;
        int               next;
        int unsigned      face;
        bit               hit;
        int unsigned      idx;
        r   = '0;
        key = (org < dst) ? {org, dst} : {dst, org};
        v   = (val == 0) ? 1 : ((val > MAX_VALENCE) ? MAX_VALENCE : val);
        hit = edge_index_of.exists(key);
        if (he_count >= MAX_HALF_EDGES || (pos == 0 && face_count >= MAX_FACES)
                || (!hit && edge_total >= MAX_EDGES)) begin
            // Full table: flag only, nothing stored
            r.overflow = 1'b1;
            overflows_seen++;
        end else begin
            prev = int'(he_count) - 1 + ((pos == 0) ? int'(v) : 0);
            next = int'(he_count) + 1 - ((pos == v - 1) ? int'(v) : 0);
            if (pos == 0) begin
                face = face_count;
                face_count++;
            end else begin
                face = (face_count == 0) ? 0 : face_count - 1;
            end
            r.half_edge      = t_he'(he_count);
            r.prev_half_edge = t_he'(prev);
            r.next_half_edge = t_he'(next);
            r.face_number    = t_face'(face);
            if (hit) begin
                idx              = edge_index_of[key];
                r.edge_number    = t_edge'(idx);
                r.has_twin       = 1'b1;
                r.twin_half_edge = edge_first_he[idx];
                twins_seen++;
            end else begin
                edge_index_of[key] = edge_total;
                edge_first_he.push_back(t_he'(he_count));
                r.edge_number      = t_edge'(edge_total);
                r.edge_is_new      = 1'b1;
                edge_total++;
            end
            he_count++;
        end
        return r;
    endfunction

    // Offer one corner word; idle between bursts, hold until accepted
    task automatic send_corner(input t_vertex org, input t_vertex dst, input t_pos pos,
                               input t_val val);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_valid           <= 1'b1;
        i_origin_vertex   <= org;
        i_dest_vertex     <= dst;
        i_corner_position <= pos;
        i_face_valence    <= val;
        do @(posedge i_clk); while (!o_ready);
        expected_words.push_back(predict_corner(org, dst, pos, val));
        items_sent++;
    endtask

    // Send the first cut corners of a face of v corners drawn from the vertex pool
    task automatic send_face(input int unsigned v, input int unsigned cut);
        t_vertex ring [MAX_VALENCE];
        for (int i = 0; i < v; i++)
            ring[i] = pool_vertex[$urandom_range(0, POOL_SIZE - 1)];
        for (int i = 0; i < cut; i++)
            send_corner(ring[i], ring[(i + 1) % v], t_pos'(i), t_val'(v));
        faces_sent++;
    endtask

    // Stray corner: any position, any valence code
    task automatic send_noise_corner();
        send_corner(pool_vertex[$urandom_range(0, POOL_SIZE - 1)],
                    pool_vertex[$urandom_range(0, POOL_SIZE - 1)],
                    t_pos'($urandom_range(0, 15)), t_val'($urandom_range(0, 31)));
    endtask

    // Drop valid and hold off until every expected word is back
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            failures++;
            if (reports < MAX_REPORTS)
                $error("%s: expected %0d, got %0d", name, want, got);
            reports++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_words.size() == 0) begin
            failures++;
            if (reports < MAX_REPORTS)
                $error("result word with no corner pending: half_edge %0d", o_half_edge);
            reports++;
        end else begin
            want = expected_words.pop_front();
            check_field("half_edge", want.half_edge, o_half_edge);
            check_field("prev_half_edge", want.prev_half_edge, o_prev_half_edge);
            check_field("next_half_edge", want.next_half_edge, o_next_half_edge);
            check_field("face_number", want.face_number, o_face_number);
            check_field("edge_number", want.edge_number, o_edge_number);
            check_field("edge_is_new", want.edge_is_new, o_edge_is_new);
            check_field("has_twin", want.has_twin, o_has_twin);
            check_field("twin_half_edge", want.twin_half_edge, o_twin_half_edge);
            check_field("overflow", want.overflow, o_overflow);
            words_checked++;
        end
    endtask

    // Check each accepted result word, then pick the next ready value
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            check_result();
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
            i_ready <= 1'b0;
        end else begin
            if (pace_left == 0) begin
                pace_kind = t_pace'($urandom_range(0, 3));
                pace_left = $urandom_range(5, 60);
            end
            pace_left--;
            case (pace_kind)
                PACE_OPEN: begin
                    i_ready <= 1'b1;
                end
                PACE_COIN: begin
                    i_ready <= 1'($urandom_range(0, 1));
                end
                PACE_MOSTLY: begin
                    i_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    i_ready <= (pace_left[1:0] != 2'd0);
                end
            endcase
        end
    end

    // Watchdog: give up when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic test_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic test_directed_corners();
        // Corner before any face start, wrap of prev below zero, extreme vertices
        send_corner(16'h0000, 16'hFFFF, 4'd3, 5'd5);
        // One-corner face, reversed key gives a twin
        send_corner(16'hFFFF, 16'h0000, 4'd0, 5'd1);
        // Valence zero acts as one
        send_corner(16'h0007, 16'h0007, 4'd0, 5'd0);
        // Triangle, then the same triangle walked backwards: every edge twinned
        send_corner(16'h0001, 16'h0002, 4'd0, 5'd3);
        send_corner(16'h0002, 16'h0003, 4'd1, 5'd3);
        send_corner(16'h0003, 16'h0001, 4'd2, 5'd3);
        send_corner(16'h0003, 16'h0002, 4'd0, 5'd3);
        send_corner(16'h0002, 16'h0001, 4'd1, 5'd3);
        send_corner(16'h0001, 16'h0003, 4'd2, 5'd3);
        // Third use of an edge still points at its first half-edge
        send_corner(16'h0001, 16'h0002, 4'd0, 5'd1);
        // Valence above the maximum saturates
        send_corner(16'h000A, 16'h000B, 4'd0, 5'd31);
        send_corner(16'h000B, 16'h000C, 4'd15, 5'd31);
        // Largest legal valence, both ends
        send_corner(16'h0014, 16'h0015, 4'd0, 5'd16);
        send_corner(16'h0015, 16'h0016, 4'd15, 5'd16);
        // Position past the valence: no end wrap; then a last corner of a two-corner face
        send_corner(16'h001E, 16'h001F, 4'd7, 5'd3);
        send_corner(16'h8000, 16'h7FFF, 4'd1, 5'd2);
        // Two-corner face sharing one edge both ways
        send_corner(16'hAAAA, 16'h5555, 4'd0, 5'd2);
        send_corner(16'h5555, 16'hAAAA, 4'd1, 5'd2);
    endtask

    // Mostly complete faces, some cut short, some stray corners
    task automatic test_random_mesh(input int unsigned count);
        int unsigned start;
        int unsigned v;
        int unsigned pick;
        start = items_sent;
        while (items_sent - start < count) begin
            pick = $urandom_range(0, 99);
            v = ($urandom_range(0, 9) < 7) ? $urandom_range(3, 6)
                                          : $urandom_range(1, MAX_VALENCE);
            if (pick < 80)
                send_face(v, v);
            else if (pick < 90)
                send_face(v, $urandom_range(1, v));
            else
                send_noise_corner();
        end
    endtask

    // Receiver holds off while faces keep coming, so the input stalls
    task automatic test_output_hold();
        int unsigned v;
        hold_request = 1'b1;
        repeat (12) begin
            v = $urandom_range(3, 5);
            send_face(v, v);
        end
    endtask

    // Sender stops until every result is back, several times
    task automatic test_drain_pause();
        repeat (4) begin
            test_random_mesh(25);
            wait_for_drain();
        end
    endtask

    initial begin
        pool_vertex[0] = 16'h0000;
        pool_vertex[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            pool_vertex[i] = t_vertex'($urandom_range(0, 16'hFFFF));

        test_reset();
        test_directed_corners();
        test_random_mesh(1700);
        test_output_hold();
        test_drain_pause();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d corners in %0d random faces; checked %0d result words",
                 items_sent, faces_sent, words_checked);
        $display("with %0d twins and %0d overflows, through a long receiver hold and drain pauses",
                 twins_seen, overflows_seen);
        if (failures == 0 && expected_words.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
